>>> hdl/bvr_pkg.sv
// Shared widths, access codes and bank-control constants for the banked video RAM controller.
package bvr_pkg;

   localparam int KIND_W     = 3;
   localparam int OFFSET_W   = 13;
   localparam int DATA_W     = 8;
   localparam int ROM_ADDR_W = 19;
   localparam int ROM_BANK_W = 4;
   localparam int GFX_SHIFT  = 12;
   localparam int GFX_SEL_W  = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ       = 3'd0,
      KIND_WRITE      = 3'd1,
      KIND_BANK_CTRL  = 3'd2,
      KIND_GFX_SEL    = 3'd3,
      KIND_BANKSWITCH = 3'd4
   } kind_type;

   localparam logic [DATA_W-1:0] MODE_VRAM     = 8'h00;
   localparam logic [DATA_W-1:0] MODE_AUX      = 8'h02;
   localparam logic [DATA_W-1:0] MODE_BANK_SEL = 8'h03;

   localparam int BS_FILL_BIT = 6;
   localparam int BS_PMC_BIT  = 7;

endpackage

>>> hdl/bvr_req_if.sv
// Request channel: one CPU bus access per item.
interface bvr_req_if import bvr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [OFFSET_W-1:0] offset;
   logic [DATA_W-1:0]   data;

   modport source (output valid, output kind, output offset, output data, input ready);
   modport sink   (input valid, input kind, input offset, input data, output ready);
endinterface

>>> hdl/bvr_rsp_if.sv
// Response channel: one result item per accepted access.
interface bvr_rsp_if import bvr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     read_data;
   logic                  from_gfx_rom;
   logic [ROM_ADDR_W-1:0] gfx_rom_address;
   logic [ROM_BANK_W-1:0] rom_bank;

   modport source (output valid, output read_data, output from_gfx_rom,
                   output gfx_rom_address, output rom_bank, input ready);
   modport sink   (input valid, input read_data, input from_gfx_rom,
                   input gfx_rom_address, input rom_bank, output ready);
endinterface

>>> hdl/bvr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/banked_video_ram_controller.sv
// Banked video RAM controller: two video RAM banks, auxiliary RAM and bank registers.
//
// Ordinary accesses are taken one per cycle while no result is held or the held one
// is being taken; each result appears in the cycle after its access is accepted, paced
// by the registered read port of the video and auxiliary RAMs, and is held until taken.
// A bankswitch write with bit 6 set fills the selected video bank through the video RAM
// write port one byte per cycle, and input stalls until the fill is done. After reset a
// clearing pass zeroes both RAMs before the first item is taken.
module banked_video_ram_controller import bvr_pkg::*; #(
   parameter int BANK_BYTES       = 8192,
   parameter int AUX_BYTES        = 2048,
   parameter int GFX_WINDOW_BYTES = 4096
) (
   input logic        clock,
   input logic        reset,
   bvr_req_if.sink    req_ch,
   bvr_rsp_if.source  rsp_ch
);

   localparam int VRAM_DEPTH = 2 * BANK_BYTES;
   localparam int VA         = $clog2(VRAM_DEPTH);
   localparam int AA         = $clog2(AUX_BYTES);
   localparam int CLEAR_N    = (VRAM_DEPTH > AUX_BYTES) ? VRAM_DEPTH : AUX_BYTES;
   localparam int CW         = $clog2(CLEAR_N);
   localparam int SW         = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;

   localparam logic [SW-1:0] BANK_SZ    = SW'(BANK_BYTES);
   localparam logic [SW-1:0] AUX_SZ     = SW'(AUX_BYTES);
   localparam logic [SW-1:0] GFX_SZ     = SW'(GFX_WINDOW_BYTES);
   localparam logic [SW-1:0] VRAM_SZ    = SW'(VRAM_DEPTH);
   localparam logic [SW-1:0] FILL_LAST  = SW'(BANK_BYTES - 1);
   localparam logic [SW-1:0] CLEAR_LAST = SW'(CLEAR_N - 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_FILL} state_type;
   typedef enum logic [1:0] {SRC_ZERO, SRC_VRAM, SRC_AUX, SRC_ROM} src_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_W-1:0]     bank_mode_ff, bank_mode_in;
   logic                  active_bank_ff, active_bank_in;
   logic                  pmc_ff, pmc_in;
   logic [DATA_W-1:0]     gfx_sel_ff, gfx_sel_in;
   logic [ROM_BANK_W-1:0] program_bank_ff, program_bank_in;
   logic                  aux0_ff, aux0_in;
   logic [DATA_W-1:0]     aux1_ff, aux1_in;
   logic                  fill_bank_ff, fill_bank_in;
   logic [DATA_W-1:0]     fill_data_ff, fill_data_in;
   logic                  s1_valid_ff, s1_valid_in;
   src_type               s1_src_ff, s1_src_in;
   logic [ROM_ADDR_W-1:0] s1_rom_addr_ff, s1_rom_addr_in;

   logic                  accept;
   logic [SW-1:0]         off_w;
   logic                  in_bank, in_aux, in_gfx;
   logic                  sum_bank;
   logic [SW-1:0]         sum_off, vsum;
   logic                  vram_we, vram_re, aux_we, aux_re;
   logic [VA-1:0]         vram_waddr;
   logic [DATA_W-1:0]     vram_wdata, vram_rdata;
   logic [AA-1:0]         aux_waddr;
   logic [DATA_W-1:0]     aux_wdata, aux_rdata;

   assign req_ch.ready = (state_ff == ST_RUN) && (!s1_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign off_w   = SW'(req_ch.offset);
   assign in_bank = off_w < BANK_SZ;
   assign in_aux  = off_w < AUX_SZ;
   assign in_gfx  = off_w < GFX_SZ;

   assign sum_bank = (state_ff == ST_FILL) ? fill_bank_ff : active_bank_ff;
   assign sum_off  = (state_ff == ST_FILL) ? SW'(cnt_ff) : off_w;
   assign vsum     = (sum_bank ? BANK_SZ : SW'(0)) + sum_off;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      bank_mode_in    = bank_mode_ff;
      active_bank_in  = active_bank_ff;
      pmc_in          = pmc_ff;
      gfx_sel_in      = gfx_sel_ff;
      program_bank_in = program_bank_ff;
      aux0_in         = aux0_ff;
      aux1_in         = aux1_ff;
      fill_bank_in    = fill_bank_ff;
      fill_data_in    = fill_data_ff;
      s1_valid_in     = s1_valid_ff;
      s1_src_in       = s1_src_ff;
      s1_rom_addr_in  = s1_rom_addr_ff;
      vram_we         = 1'b0;
      vram_re         = 1'b0;
      vram_waddr      = vsum[VA-1:0];
      vram_wdata      = req_ch.data;
      aux_we          = 1'b0;
      aux_re          = 1'b0;
      aux_waddr       = AA'(req_ch.offset);
      aux_wdata       = req_ch.data;

      if (rsp_ch.valid && rsp_ch.ready) begin
         s1_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            vram_we    = SW'(cnt_ff) < VRAM_SZ;
            vram_waddr = VA'(cnt_ff);
            vram_wdata = '0;
            aux_we     = SW'(cnt_ff) < AUX_SZ;
            aux_waddr  = AA'(cnt_ff);
            aux_wdata  = '0;
            cnt_in     = cnt_ff + 1'b1;
            if (SW'(cnt_ff) == CLEAR_LAST) begin
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_FILL: begin
            vram_we    = 1'b1;
            vram_wdata = fill_data_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (SW'(cnt_ff) == FILL_LAST) begin
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (accept) begin
               s1_valid_in    = 1'b1;
               s1_src_in      = SRC_ZERO;
               s1_rom_addr_in = '0;
               case (req_ch.kind)
                  KIND_READ: begin
                     if (gfx_sel_ff != '0 && in_gfx) begin
                        s1_src_in      = SRC_ROM;
                        s1_rom_addr_in = {gfx_sel_ff[GFX_SEL_W-1:0], GFX_SHIFT'(0)}
                                       + ROM_ADDR_W'(req_ch.offset);
                     end else if (bank_mode_ff == MODE_VRAM) begin
                        if (in_bank) begin
                           s1_src_in = SRC_VRAM;
                           vram_re   = 1'b1;
                        end
                     end else if (bank_mode_ff == MODE_AUX && in_aux) begin
                        s1_src_in = SRC_AUX;
                        aux_re    = 1'b1;
                     end
                  end
                  KIND_WRITE: begin
                     if (bank_mode_ff == MODE_BANK_SEL && req_ch.offset == '0
                         && req_ch.data[DATA_W-1:1] == '0) begin
                        active_bank_in = req_ch.data[0];
                     end else if (bank_mode_ff == MODE_VRAM) begin
                        vram_we = pmc_ff && in_bank;
                     end else if (bank_mode_ff == MODE_AUX && in_aux) begin
                        aux_we = pmc_ff;
                        if (pmc_ff && off_w == SW'(0)) begin
                           aux0_in = req_ch.data[0];
                        end
                        if (pmc_ff && off_w == SW'(1)) begin
                           aux1_in = req_ch.data;
                        end
                     end
                  end
                  KIND_BANK_CTRL: begin
                     bank_mode_in = req_ch.data;
                  end
                  KIND_GFX_SEL: begin
                     gfx_sel_in = req_ch.data;
                  end
                  KIND_BANKSWITCH: begin
                     program_bank_in = req_ch.data[ROM_BANK_W-1:0];
                     pmc_in          = req_ch.data[BS_PMC_BIT];
                     if (req_ch.data[BS_FILL_BIT]) begin
                        fill_bank_in = aux0_ff;
                        fill_data_in = aux1_ff;
                        cnt_in       = '0;
                        state_in     = ST_FILL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         cnt_ff          <= '0;
         bank_mode_ff    <= '0;
         active_bank_ff  <= 1'b0;
         pmc_ff          <= 1'b0;
         gfx_sel_ff      <= '0;
         program_bank_ff <= '0;
         aux0_ff         <= 1'b0;
         aux1_ff         <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         bank_mode_ff    <= bank_mode_in;
         active_bank_ff  <= active_bank_in;
         pmc_ff          <= pmc_in;
         gfx_sel_ff      <= gfx_sel_in;
         program_bank_ff <= program_bank_in;
         aux0_ff         <= aux0_in;
         aux1_ff         <= aux1_in;
         s1_valid_ff     <= s1_valid_in;
      end
      fill_bank_ff   <= fill_bank_in;
      fill_data_ff   <= fill_data_in;
      s1_src_ff      <= s1_src_in;
      s1_rom_addr_ff <= s1_rom_addr_in;
   end

   bvr_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_DEPTH)) u_vram (
      .clock (clock),
      .we    (vram_we),
      .waddr (vram_waddr),
      .wdata (vram_wdata),
      .re    (vram_re),
      .raddr (vsum[VA-1:0]),
      .rdata (vram_rdata)
   );

   bvr_ram #(.WIDTH(DATA_W), .DEPTH(AUX_BYTES)) u_aux (
      .clock (clock),
      .we    (aux_we),
      .waddr (aux_waddr),
      .wdata (aux_wdata),
      .re    (aux_re),
      .raddr (AA'(req_ch.offset)),
      .rdata (aux_rdata)
   );

   always_comb begin
      case (s1_src_ff)
         SRC_VRAM: rsp_ch.read_data = vram_rdata;
         SRC_AUX:  rsp_ch.read_data = aux_rdata;
         default:  rsp_ch.read_data = '0;
      endcase
   end

   assign rsp_ch.valid           = s1_valid_ff;
   assign rsp_ch.from_gfx_rom    = (s1_src_ff == SRC_ROM);
   assign rsp_ch.gfx_rom_address = s1_rom_addr_ff;
   assign rsp_ch.rom_bank        = program_bank_ff;

endmodule

>>> hdl/bvr_checker.sv
// Port-level checks for the banked video RAM controller, bound to the top level.
module bvr_checker import bvr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_W-1:0]     rsp_read_data,
   input logic                  rsp_from_gfx_rom,
   input logic [ROM_ADDR_W-1:0] rsp_gfx_rom_address,
   input logic [ROM_BANK_W-1:0] rsp_rom_bank
);

   a_reset_clears : assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input taken right after reset, before the clearing pass");

   a_item_answers : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result in the next cycle");

   a_rom_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_gfx_rom |-> rsp_read_data == '0)
      else $error("graphics ROM result carries read data");

   a_addr_only_rom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_gfx_rom |-> rsp_gfx_rom_address == '0)
      else $error("ROM address shown on a result not served by ROM");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_from_gfx_rom) && $stable(rsp_gfx_rom_address)
         && $stable(rsp_rom_bank))
      else $error("stalled result changed");

endmodule

bind banked_video_ram_controller bvr_checker u_bvr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_read_data       (rsp_ch.read_data),
   .rsp_from_gfx_rom    (rsp_ch.from_gfx_rom),
   .rsp_gfx_rom_address (rsp_ch.gfx_rom_address),
   .rsp_rom_bank        (rsp_ch.rom_bank)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the banked video RAM controller with a built-in bus access predictor.
module tb_top;
   import bvr_pkg::*;

   localparam int VRAM_BANK_BYTES  = 8192;
   localparam int AUX_RAM_BYTES    = 2048;
   localparam int GFX_WINDOW_SIZE  = 4096;
   localparam int RANDOM_ACCESSES  = 1225;
   localparam int MAX_FILLS        = 10;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int WATCHDOG_LIMIT   = 80000;
   localparam int SETTLE_CYCLES    = 16;

   localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 3'd7;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   data;
      bit                  after_drain;
   } bus_access_type;

   typedef struct {
      logic [DATA_W-1:0]     read_data;
      logic                  from_gfx_rom;
      logic [ROM_ADDR_W-1:0] gfx_rom_address;
      logic [ROM_BANK_W-1:0] rom_bank;
   } bus_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bvr_req_if req_ch ();
   bvr_rsp_if rsp_ch ();

   banked_video_ram_controller #(
      .BANK_BYTES       (VRAM_BANK_BYTES),
      .AUX_BYTES        (AUX_RAM_BYTES),
      .GFX_WINDOW_BYTES (GFX_WINDOW_SIZE)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [DATA_W-1:0]     video_mem [2*VRAM_BANK_BYTES];
   logic [DATA_W-1:0]     aux_mem [AUX_RAM_BYTES];
   logic [DATA_W-1:0]     mode_reg;
   logic                  active_bank;
   logic                  pmc_bit;
   logic [DATA_W-1:0]     gfx_sel;
   logic [ROM_BANK_W-1:0] prog_bank;

   bus_access_type bus_accesses [$];
   bus_reply_type  replies_due_q [$];
   int unsigned replies_due    = 0;
   int unsigned accesses_taken = 0;
   int unsigned item_total     = 0;
   int unsigned mismatches     = 0;
   int unsigned replies_seen   = 0;
   int unsigned req_gap        = 0;
   int unsigned req_calm       = 0;
   int unsigned rsp_wait       = 0;
   int unsigned rsp_calm       = 0;
   int unsigned hold_left      = 0;
   int unsigned quiet_cycles   = 0;
   logic        rsp_holding    = 1'b0;
   bus_access_type next_access;

   function automatic bus_reply_type apply_access(logic [KIND_W-1:0] kind,
                                                  logic [OFFSET_W-1:0] offset,
                                                  logic [DATA_W-1:0] data);
      bus_reply_type r;
      logic [OFFSET_W:0] vidx;
      r.read_data       = '0;
      r.from_gfx_rom    = 1'b0;
      r.gfx_rom_address = '0;
      vidx = {active_bank, offset};
      case (kind)
         KIND_READ: begin
            if (gfx_sel != '0 && offset < GFX_WINDOW_SIZE) begin
               r.from_gfx_rom    = 1'b1;
               r.gfx_rom_address = {gfx_sel[GFX_SEL_W-1:0], {GFX_SHIFT{1'b0}}}
                                   + ROM_ADDR_W'(offset);
            end else if (mode_reg == MODE_VRAM) begin
               r.read_data = video_mem[vidx];
            end else if (mode_reg == MODE_AUX && offset < AUX_RAM_BYTES) begin
               r.read_data = aux_mem[offset];
            end
         end
         KIND_WRITE: begin
            if (mode_reg == MODE_BANK_SEL && offset == '0 && data[DATA_W-1:1] == '0) begin
               active_bank = data[0];
            end else if (mode_reg == MODE_VRAM) begin
               if (pmc_bit) video_mem[vidx] = data;
            end else if (mode_reg == MODE_AUX && offset < AUX_RAM_BYTES) begin
               if (pmc_bit) aux_mem[offset] = data;
            end
         end
         KIND_BANK_CTRL: mode_reg = data;
         KIND_GFX_SEL: gfx_sel = data;
         KIND_BANKSWITCH: begin
            prog_bank = data[ROM_BANK_W-1:0];
            if (data[BS_FILL_BIT]) begin
               for (int i = 0; i < VRAM_BANK_BYTES; i++)
                  video_mem[aux_mem[0][0]*VRAM_BANK_BYTES + i] = aux_mem[1];
            end
            pmc_bit = data[BS_PMC_BIT];
         end
         default: ;
      endcase
      r.rom_bank = prog_bank;
      return r;
   endfunction

   function automatic void queue_access(logic [KIND_W-1:0] k, logic [OFFSET_W-1:0] o,
                                        logic [DATA_W-1:0] d, bit drain);
      bus_access_type a;
      a.kind        = k;
      a.offset      = o;
      a.data        = d;
      a.after_drain = drain;
      bus_accesses.push_back(a);
   endfunction

   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic void match_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold the offered item
      end else if (req_gap != 0) begin
         req_ch.valid <= 1'b0;
         req_gap--;
      end else if (bus_accesses.size() != 0 &&
                   (!bus_accesses[0].after_drain || (!req_ch.valid && replies_due == 0))) begin
         next_access = bus_accesses.pop_front();
         req_ch.valid  <= 1'b1;
         req_ch.kind   <= next_access.kind;
         req_ch.offset <= next_access.offset;
         req_ch.data   <= next_access.data;
         req_gap = rsp_holding ? 0 : draw_wait(req_calm);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      bus_reply_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_holding  <= 1'b0;
         rsp_wait  = 0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (replies_due_q.size() == 0) begin
               $display("%0t: unexpected item read_data %0h from_gfx_rom %0b addr %0h bank %0h",
                        $time, rsp_ch.read_data, rsp_ch.from_gfx_rom,
                        rsp_ch.gfx_rom_address, rsp_ch.rom_bank);
               mismatches++;
            end else begin
               want = replies_due_q.pop_front();
               match_field("read_data", 32'(want.read_data), 32'(rsp_ch.read_data));
               match_field("from_gfx_rom", 32'(want.from_gfx_rom),
                           32'(rsp_ch.from_gfx_rom));
               match_field("gfx_rom_address", 32'(want.gfx_rom_address),
                           32'(rsp_ch.gfx_rom_address));
               match_field("rom_bank", 32'(want.rom_bank), 32'(rsp_ch.rom_bank));
            end
            replies_seen++;
            if (replies_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
            else rsp_wait = draw_wait(rsp_calm);
         end
         if (req_ch.valid && req_ch.ready) begin
            replies_due_q.push_back(apply_access(req_ch.kind, req_ch.offset, req_ch.data));
            accesses_taken <= accesses_taken + 1;
         end
         replies_due  <= replies_due_q.size();
         rsp_ch.ready <= (hold_left == 0 && rsp_wait == 0);
         rsp_holding  <= (hold_left != 0);
         if (hold_left != 0) hold_left--;
         else if (rsp_wait != 0) rsp_wait--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("banked_video_ram_controller regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned         pick;
      int unsigned         fills;
      logic [KIND_W-1:0]   k;
      logic [OFFSET_W-1:0] off;
      logic [DATA_W-1:0]   d;

      req_ch.valid  = 1'b0;
      req_ch.kind   = '0;
      req_ch.offset = '0;
      req_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
      foreach (video_mem[i]) video_mem[i] = '0;
      foreach (aux_mem[i]) aux_mem[i] = '0;
      mode_reg    = '0;
      active_bank = 1'b0;
      pmc_bit     = 1'b0;
      gfx_sel     = '0;
      prog_bank   = '0;
      fills       = 0;

      queue_access(KIND_READ, 13'd0, 8'h00, 1'b0);
      queue_access(KIND_WRITE, 13'd0, 8'hff, 1'b0);
      queue_access(KIND_BANKSWITCH, 13'd0, 8'h80, 1'b0);
      queue_access(KIND_WRITE, 13'd0, 8'hff, 1'b0);
      queue_access(KIND_WRITE, 13'd8191, 8'ha5, 1'b0);
      queue_access(KIND_READ, 13'd8191, 8'h00, 1'b0);
      queue_access(KIND_BANK_CTRL, 13'd0, MODE_BANK_SEL, 1'b0);
      queue_access(KIND_WRITE, 13'd0, 8'h01, 1'b0);
      queue_access(KIND_WRITE, 13'd0, 8'h02, 1'b0);
      queue_access(KIND_BANK_CTRL, 13'd0, MODE_AUX, 1'b0);
      queue_access(KIND_WRITE, 13'd0, 8'h01, 1'b0);
      queue_access(KIND_WRITE, 13'd1, 8'h3c, 1'b0);
      queue_access(KIND_WRITE, 13'd2047, 8'h77, 1'b0);
      queue_access(KIND_WRITE, 13'd2048, 8'h11, 1'b0);
      queue_access(KIND_READ, 13'd2047, 8'h00, 1'b0);
      queue_access(KIND_READ, 13'd2048, 8'h00, 1'b0);
      queue_access(KIND_BANKSWITCH, 13'h1fff, 8'hff, 1'b0);
      queue_access(KIND_BANK_CTRL, 13'd0, MODE_VRAM, 1'b0);
      queue_access(KIND_READ, 13'd100, 8'h00, 1'b0);
      queue_access(KIND_GFX_SEL, 13'd0, 8'hff, 1'b0);
      queue_access(KIND_READ, 13'd4095, 8'hff, 1'b0);
      queue_access(KIND_READ, 13'd4096, 8'h00, 1'b0);
      queue_access(KIND_GFX_SEL, 13'd0, 8'h00, 1'b0);
      queue_access(KIND_LAST_UNUSED, 13'h1fff, 8'hff, 1'b0);
      queue_access(KIND_BANK_CTRL, 13'd0, 8'h80, 1'b0);

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         case ($urandom_range(0, 3))
            0: off = OFFSET_W'($urandom_range(0, 2**OFFSET_W - 1));
            1: off = OFFSET_W'($urandom_range(0, AUX_RAM_BYTES - 1));
            2: off = OFFSET_W'($urandom_range(0, 15));
            default: begin
               case ($urandom_range(0, 5))
                  0: off = '0;
                  1: off = OFFSET_W'(AUX_RAM_BYTES - 1);
                  2: off = OFFSET_W'(AUX_RAM_BYTES);
                  3: off = OFFSET_W'(GFX_WINDOW_SIZE - 1);
                  4: off = OFFSET_W'(GFX_WINDOW_SIZE);
                  default: off = OFFSET_W'(VRAM_BANK_BYTES - 1);
               endcase
            end
         endcase
         d    = DATA_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            k = KIND_READ;
         end else if (pick < 75) begin
            k = KIND_WRITE;
            if ($urandom_range(0, 3) == 0) begin
               off = '0;
               d   = DATA_W'($urandom_range(0, 2));
            end
         end else if (pick < 82) begin
            k = KIND_BANK_CTRL;
            case ($urandom_range(0, 6))
               0, 1: d = MODE_VRAM;
               2, 3: d = MODE_AUX;
               4: d = MODE_BANK_SEL;
               default: ;
            endcase
         end else if (pick < 89) begin
            k = KIND_GFX_SEL;
            if ($urandom_range(0, 2) != 0) d = '0;
         end else if (pick < 97) begin
            k = KIND_BANKSWITCH;
            d[BS_PMC_BIT]  = ($urandom_range(0, 4) != 0);
            d[BS_FILL_BIT] = (fills < MAX_FILLS && $urandom_range(0, 7) == 0);
            if (d[BS_FILL_BIT]) fills++;
         end else begin
            k = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
         end
         queue_access(k, off, d, n == RANDOM_ACCESSES / 2);
      end
      item_total = bus_accesses.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (accesses_taken != item_total || replies_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("banked_video_ram_controller regression: pass");
      end else begin
         $display("banked_video_ram_controller regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/bvr_pkg.sv
hdl/bvr_req_if.sv
hdl/bvr_rsp_if.sv
hdl/bvr_ram.sv
hdl/banked_video_ram_controller.sv
hdl/bvr_checker.sv
tb/sv/tb_top.sv
